>>> src/sfp_pkg.sv
// Shared types, constants and byte-level helpers of the sensor frame packer.
// No dependencies; every design file of the block imports it, the checker does not.
`default_nettype none

package sfp_pkg;

    localparam int HEADER_LEN = 13;
    localparam int PREFIX_MAX = 16;
    localparam int NUM_DIGITS = 6;
    localparam int FRAME_FIXED = HEADER_LEN + 7 + 3;

    localparam logic [3:0] HDR_LAST = 4'(HEADER_LEN - 1);
    localparam logic [3:0] DIG_LAST = 4'(NUM_DIGITS - 1);

    localparam logic [7:0]  CRC8_POLY  = 8'h07;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [7:0]  CRC8_INIT  = 8'h00;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;

    localparam logic [2:0] REG_HEADER_TEMPLATE = 3'd0;
    localparam logic [2:0] REG_PREFIX_LENGTH   = 3'd1;
    localparam logic [2:0] REG_PREFIX_LOW      = 3'd2;
    localparam logic [2:0] REG_PREFIX_HIGH     = 3'd3;
    localparam logic [2:0] REG_FRAME_LIMIT     = 3'd4;

    localparam logic [7:0] FRAME_LIMIT_RESET = 8'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJECT,
        ST_HEADER,
        ST_PREFIX,
        ST_SIGN,
        ST_DIGITS,
        ST_CRC8,
        ST_CRC16_HI,
        ST_CRC16_LO
    } state_t;

    typedef enum logic [2:0] {
        SEL_HEADER,
        SEL_PREFIX,
        SEL_SIGN,
        SEL_DIGIT,
        SEL_CRC8,
        SEL_CRC16_HI,
        SEL_CRC16_LO,
        SEL_REJECT
    } sel_t;

    typedef struct packed {
        logic       capture;
        logic       emit;
        sel_t       sel;
        logic [3:0] idx;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic       out_free;
        logic       oversize;
        logic       conv_done;
        logic       negative;
        logic       digit_zero;
        logic [4:0] plen;
    } status_t;

    function automatic logic [29:0] pow62(input logic [2:0] k);
        logic [29:0] p;
        unique case (k)
            3'd0:    p = 30'd916132832;
            3'd1:    p = 30'd14776336;
            3'd2:    p = 30'd238328;
            3'd3:    p = 30'd3844;
            3'd4:    p = 30'd62;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = 8'h30 + {2'b00, d};
        end else if (d < 6'd36) begin
            c = 8'h57 + {2'b00, d};
        end else if (d < 6'd62) begin
            c = 8'h1D + {2'b00, d};
        end else begin
            c = 8'h5A;
        end
        return c;
    endfunction

    function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ((r << 1) ^ CRC8_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ((r << 1) ^ CRC16_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/sensor_frame_packer.sv
// Top level of the sensor frame packer: sequencer plus datapath.
// Depends on sfp_pkg, sfp_ctrl, sfp_datapath (and sfp_conv below it).
//
//   channel  | direction | handshake            | payload
//   s_       | in        | s_tvalid / s_tready  | tdata: transaction_id, seconds, reading
//   m_       | out       | m_tvalid / m_tready  | tdata: out_byte, frame_total; tuser; tlast
//   cfg_     | in        | cfg_wr_en            | cfg_index, cfg_wdata
//
// One frame byte per cycle unless m_tready stalls or the sequencer waits; a frame
// is 17 to 39 bytes. A reading is accepted only between frames, so a new reading
// is not taken while a frame is in flight. A non-negative reading leaves an empty
// sign slot, each dropped leading zero digit costs an idle step, and the sequencer
// waits on the base-62 converter when the prefix is under 4 bytes.
// Reset is synchronous; no clearing pass. A stalled m_tready holds the sequencer.
`default_nettype none

module sensor_frame_packer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [7:0] transaction_id, [39:8] seconds, [71:40] reading
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [13:8] frame_total, [15:14] zero
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // [0] rejected
);
    import sfp_pkg::*;

    cmd_t    cmd;
    status_t status;

    sfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> src/sfp_conv.sv
// Base-62 converter: restoring radix-4 division by each power of 62, two
// quotient bits per cycle, six digits into a small register file. Uses sfp_pkg.
`default_nettype none

module sfp_conv (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] start_mag,
    input  wire logic [2:0]  rd_idx,
    output logic             done,
    output logic [5:0]       rd_digit
);
    import sfp_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  k_reg, k_next;
    logic [1:0]  j_reg, j_next;
    logic [31:0] rem_reg, rem_next;
    logic [3:0]  q_reg, q_next;
    logic [5:0]  digit_reg [0:NUM_DIGITS-1];

    logic [37:0] m1, m2, m3, r_ext, sub;
    logic [1:0]  q;

    always_comb begin
        m1    = 38'(pow62(k_reg)) << {j_reg, 1'b0};
        m2    = m1 << 1;
        m3    = m1 + m2;
        r_ext = {6'd0, rem_reg};
        priority if (r_ext >= m3) begin
            q = 2'd3; sub = m3;
        end else if (r_ext >= m2) begin
            q = 2'd2; sub = m2;
        end else if (r_ext >= m1) begin
            q = 2'd1; sub = m1;
        end else begin
            q = 2'd0; sub = 38'd0;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        k_next    = k_reg;
        j_next    = j_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            k_next    = 3'd0;
            j_next    = 2'd2;
            rem_next  = start_mag;
        end else if (busy_reg) begin
            rem_next = 32'(r_ext - sub);
            q_next   = {q_reg[1:0], q};
            if (j_reg == 2'd0) begin
                j_next = 2'd2;
                if (k_reg == 3'(NUM_DIGITS - 1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end else begin
                j_next = j_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= 3'd0;
            j_reg    <= 2'd2;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
            j_reg    <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (busy_reg && !start && j_reg == 2'd0) begin
            digit_reg[k_reg] <= {q_reg, q};
        end
    end

    assign done     = done_reg;
    assign rd_digit = digit_reg[rd_idx];

endmodule

`default_nettype wire

>>> src/sfp_ctrl.sv
// Frame sequencer: walks header, prefix, sign, digits and trailer phases and
// issues one byte command per output transfer. Uses sfp_pkg command/status types.
`default_nettype none

module sfp_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire sfp_pkg::status_t status,
    output sfp_pkg::cmd_t         cmd
);
    import sfp_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic       started_reg, started_next;
    logic       skip;

    // leading zero digits are dropped, the units digit never
    assign skip = status.digit_zero && !started_reg && (idx_reg != DIG_LAST);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        started_next = started_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next   = status.oversize ? ST_REJECT : ST_HEADER;
                    idx_next     = 4'd0;
                    started_next = 1'b0;
                end
            end
            ST_REJECT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_HEADER: begin
                if (status.out_free) begin
                    if (idx_reg == HDR_LAST) begin
                        idx_next   = 4'd0;
                        state_next = (status.plen == 5'd0) ? ST_SIGN : ST_PREFIX;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            ST_PREFIX: begin
                if (status.out_free) begin
                    if (({1'b0, idx_reg} + 5'd1) == status.plen) begin
                        idx_next   = 4'd0;
                        state_next = ST_SIGN;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            ST_SIGN: begin
                if (!status.negative || status.out_free) state_next = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (status.conv_done) begin
                    if (skip) begin
                        idx_next = idx_reg + 4'd1;
                    end else if (status.out_free) begin
                        started_next = 1'b1;
                        if (idx_reg == DIG_LAST) begin
                            state_next = ST_CRC8;
                        end else begin
                            idx_next = idx_reg + 4'd1;
                        end
                    end
                end
            end
            ST_CRC8: begin
                if (status.out_free) state_next = ST_CRC16_HI;
            end
            ST_CRC16_HI: begin
                if (status.out_free) state_next = ST_CRC16_LO;
            end
            ST_CRC16_LO: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.sel     = SEL_HEADER;
        cmd.idx     = idx_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_REJECT: begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_REJECT;
                cmd.last = 1'b1;
            end
            ST_HEADER: begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_HEADER;
            end
            ST_PREFIX: begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_PREFIX;
            end
            ST_SIGN: begin
                cmd.emit = status.out_free && status.negative;
                cmd.sel  = SEL_SIGN;
            end
            ST_DIGITS: begin
                cmd.emit = status.out_free && status.conv_done && !skip;
                cmd.sel  = SEL_DIGIT;
            end
            ST_CRC8: begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_CRC8;
            end
            ST_CRC16_HI: begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_CRC16_HI;
            end
            ST_CRC16_LO: begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_CRC16_LO;
                cmd.last = 1'b1;
            end
            default: begin
                cmd.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= 4'd0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sfp_datapath.sv
// Datapath: configuration registers, captured reading, CRC accumulators,
// byte selection and output register. Uses sfp_pkg and sfp_conv.
`default_nettype none

module sfp_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [63:0]   cfg_wdata,
    input  wire logic [71:0]   s_tdata,
    input  wire sfp_pkg::cmd_t cmd,
    output sfp_pkg::status_t   status,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata,
    output logic               m_tlast,
    output logic [0:0]         m_tuser
);
    import sfp_pkg::*;

    logic [47:0]  header_template_reg;
    logic [4:0]   prefix_length_reg;
    logic [63:0]  prefix_low_reg;
    logic [63:0]  prefix_high_reg;
    logic [7:0]   frame_limit_reg;

    logic [7:0]   tid_reg;
    logic [31:0]  secs_reg;
    logic         neg_reg;
    logic [7:0]   crc8_reg, crc8_next;
    logic [15:0]  crc16_reg, crc16_next;
    logic [5:0]   count_reg, count_next;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [15:0]  m_tdata_reg, m_tdata_next;
    logic         m_tlast_reg, m_tlast_next;
    logic         m_tuser_reg, m_tuser_next;

    logic [31:0]  reading;
    logic [31:0]  mag;
    logic [4:0]   plen;
    logic [127:0] prefix_cat;
    logic [7:0]   hdr_byte;
    logic [7:0]   out_byte;
    logic [5:0]   digit;
    logic         conv_done;
    logic         out_free;

    assign reading    = s_tdata[71:40];
    assign mag        = reading[31] ? (32'd0 - reading) : reading;
    assign plen       = (prefix_length_reg > 5'(PREFIX_MAX)) ? 5'(PREFIX_MAX) : prefix_length_reg;
    assign prefix_cat = {prefix_high_reg, prefix_low_reg};
    assign out_free   = !m_tvalid_reg || m_tready;

    sfp_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.capture),
        .start_mag (mag),
        .rd_idx    (cmd.idx[2:0]),
        .done      (conv_done),
        .rd_digit  (digit)
    );

    always_comb begin
        status.out_free   = out_free;
        status.oversize   = ({4'd0, plen} + 9'(FRAME_FIXED)) > {1'b0, frame_limit_reg};
        status.conv_done  = conv_done;
        status.negative   = neg_reg;
        status.digit_zero = (digit == 6'd0);
        status.plen       = plen;
    end

    always_comb begin
        unique case (cmd.idx)
            4'd0:    hdr_byte = header_template_reg[47:40];
            4'd1:    hdr_byte = header_template_reg[39:32];
            4'd2:    hdr_byte = header_template_reg[31:24];
            4'd3:    hdr_byte = header_template_reg[23:16];
            4'd4:    hdr_byte = header_template_reg[15:8];
            4'd5:    hdr_byte = header_template_reg[7:0];
            4'd6:    hdr_byte = tid_reg;
            4'd9:    hdr_byte = secs_reg[31:24];
            4'd10:   hdr_byte = secs_reg[23:16];
            4'd11:   hdr_byte = secs_reg[15:8];
            4'd12:   hdr_byte = secs_reg[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        crc8_next  = crc8_reg;
        crc16_next = crc16_reg;
        count_next = count_reg;
        unique case (cmd.sel)
            SEL_HEADER:   out_byte = hdr_byte;
            SEL_PREFIX:   out_byte = prefix_cat[{cmd.idx, 3'b000} +: 8];
            SEL_SIGN:     out_byte = CHAR_MINUS;
            SEL_DIGIT:    out_byte = digit_char(digit);
            SEL_CRC8:     out_byte = crc8_reg;
            SEL_CRC16_HI: out_byte = crc16_reg[15:8];
            SEL_CRC16_LO: out_byte = crc16_reg[7:0];
            SEL_REJECT:   out_byte = 8'h00;
            default:      out_byte = 8'h00;
        endcase
        if (cmd.capture) begin
            crc8_next  = CRC8_INIT;
            crc16_next = CRC16_INIT;
            count_next = 6'd0;
        end else if (cmd.emit) begin
            count_next = count_reg + 6'd1;
            if (cmd.sel == SEL_PREFIX || cmd.sel == SEL_SIGN || cmd.sel == SEL_DIGIT) begin
                crc8_next = crc8_update(crc8_reg, out_byte);
            end
            if (cmd.sel != SEL_CRC16_HI && cmd.sel != SEL_CRC16_LO
                && cmd.sel != SEL_REJECT) begin
                crc16_next = crc16_update(crc16_reg, out_byte);
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = cmd.last;
            m_tuser_next  = (cmd.sel == SEL_REJECT);
            if (cmd.last && cmd.sel != SEL_REJECT) begin
                m_tdata_next = {2'b00, count_reg + 6'd1, out_byte};
            end else begin
                m_tdata_next = {8'h00, out_byte};
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_template_reg <= 48'd0;
            prefix_length_reg   <= 5'd0;
            prefix_low_reg      <= 64'd0;
            prefix_high_reg     <= 64'd0;
            frame_limit_reg     <= FRAME_LIMIT_RESET;
            m_tvalid_reg        <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_HEADER_TEMPLATE: header_template_reg <= cfg_wdata[47:0];
                    REG_PREFIX_LENGTH:   prefix_length_reg   <= cfg_wdata[4:0];
                    REG_PREFIX_LOW:      prefix_low_reg      <= cfg_wdata;
                    REG_PREFIX_HIGH:     prefix_high_reg     <= cfg_wdata;
                    REG_FRAME_LIMIT:     frame_limit_reg     <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tid_reg  <= s_tdata[7:0];
            secs_reg <= s_tdata[39:8];
            neg_reg  <= reading[31];
        end
        crc8_reg    <= crc8_next;
        crc16_reg   <= crc16_next;
        count_reg   <= count_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

>>> src/sfp_checker.sv
// Port-level checks of the sensor frame packer output stream, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module sfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [0:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output transfer changed while stalled");

    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 16'h0000))
        else $error("rejected result not a single empty last transfer");

    a_total_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[15:8] == 8'h00))
        else $error("frame_total nonzero before last byte");

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser[0] |-> (m_tdata[13:8] >= 6'd17)
                                              && (m_tdata[13:8] <= 6'd39))
        else $error("frame_total out of range");

endmodule

bind sensor_frame_packer sfp_checker u_sfp_checker (.*);

`default_nettype wire
